[sv/cgft_pkg.sv]
// cgft_pkg: shared types and constants for the camera goal frame tracker
// no dependencies; imported by camera_goal_frame_tracker
`default_nettype none

package cgft_pkg;

    // input kinds carried on s_tuser
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // goal colour register codes
    localparam logic [1:0] COLOR_BLUE   = 2'd1;
    localparam logic [1:0] COLOR_YELLOW = 2'd2;

    // register indexes on the configuration port
    localparam logic [1:0] REG_GOAL_COLOR   = 2'd0;
    localparam logic [1:0] REG_NEAR_LIMIT   = 2'd1;
    localparam logic [1:0] REG_FAR_LIMIT    = 2'd2;
    localparam logic [1:0] REG_RETURN_DELAY = 2'd3;

    localparam logic [1:0]  GOAL_COLOR_RST   = 2'd1;
    localparam logic [7:0]  NEAR_LIMIT_RST   = 8'd150;
    localparam logic [7:0]  FAR_LIMIT_RST    = 8'd160;
    localparam logic [15:0] RETURN_DELAY_RST = 16'd1000;

    localparam logic [7:0]  SYNC_BYTE     = 8'd255;
    localparam logic [7:0]  Y_SEEN_LIMIT  = 8'd250;
    localparam logic [11:0] ANGLE_OFFSET  = 12'd1210;
    localparam logic [2:0]  PAYLOAD_BYTES = 3'd5;
    localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  goal_x;
        logic [11:0] angle_tenths;
        logic        return_active;
        logic        goal_seen;
        logic        frame_ok;
    } result_t;

endpackage

`default_nettype wire

[sv/camera_goal_frame_tracker.sv]
// camera_goal_frame_tracker: six-byte camera frame parser with goal angle and return flag
// depends on cgft_pkg for codes, constants and the result struct
// output: a result is registered into the result or skid register on the footer byte transfer
// throughput: one input transfer per cycle while s_tready is high; a two-entry
// output buffer (result plus skid register) keeps s_tready high while m_tready is high
// reset: synchronous active-low aresetn clears framing, tracking state, buffer
// valid flags and loads the register defaults; the frame byte store is not reset
`default_nettype none

module camera_goal_frame_tracker
    import cgft_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  wire logic        s_tuser,    // [0] operation

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,    // [0] goal_seen, [1] return_active,
                                         // [13:2] angle_tenths, [21:14] goal_x, [23:22] zero
    output logic             m_tuser,    // [0] frame_ok

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // configuration registers
    logic [1:0]  goal_color_reg;
    logic [7:0]  near_limit_reg;
    logic [7:0]  far_limit_reg;
    logic [15:0] return_delay_reg;

    // tracking state
    logic [2:0]  bytes_seen_reg, bytes_seen_next;
    logic        discard_reg, discard_next;
    logic [7:0]  frame_store [0:4];
    logic [7:0]  prev_x_reg, prev_x_next;
    logic [7:0]  prev_y_reg, prev_y_next;
    logic [11:0] angle_reg, angle_next;
    logic        return_reg, return_next;
    logic [15:0] elapsed_reg, elapsed_next;

    // output buffer
    logic        out_valid_reg, skid_valid_reg;
    result_t     out_data_reg, skid_data_reg;

    logic        in_xfer, out_xfer, cfg_wr;
    logic        store_wr, push;
    result_t     result;
    logic        frame_good, seen;
    logic [7:0]  sel_y, sel_x;
    logic [15:0] elapsed_eff;
    logic        restart_timer;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg.goal_x, out_data_reg.angle_tenths,
                       out_data_reg.return_active, out_data_reg.goal_seen};
    assign m_tuser  = out_data_reg.frame_ok;

    // ---------------- configuration port ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            goal_color_reg   <= GOAL_COLOR_RST;
            near_limit_reg   <= NEAR_LIMIT_RST;
            far_limit_reg    <= FAR_LIMIT_RST;
            return_delay_reg <= RETURN_DELAY_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_GOAL_COLOR:   goal_color_reg   <= pwdata[1:0];
                REG_NEAR_LIMIT:   near_limit_reg   <= pwdata[7:0];
                REG_FAR_LIMIT:    far_limit_reg    <= pwdata[7:0];
                REG_RETURN_DELAY: return_delay_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_GOAL_COLOR:   prdata = {30'd0, goal_color_reg};
            REG_NEAR_LIMIT:   prdata = {24'd0, near_limit_reg};
            REG_FAR_LIMIT:    prdata = {24'd0, far_limit_reg};
            REG_RETURN_DELAY: prdata = {16'd0, return_delay_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // ---------------- frame evaluation ----------------
    always_comb begin
        unique case (goal_color_reg)
            COLOR_BLUE: begin
                sel_y = frame_store[1];
                sel_x = frame_store[2];
            end
            COLOR_YELLOW: begin
                sel_y = frame_store[3];
                sel_x = frame_store[4];
            end
            default: begin
                // unknown colour reuses the last selected pair
                sel_y = prev_y_reg;
                sel_x = prev_x_reg;
            end
        endcase
    end

    assign frame_good    = (frame_store[0] == SYNC_BYTE) && (s_tdata == SYNC_BYTE);
    assign seen          = sel_y < Y_SEEN_LIMIT;
    assign restart_timer = (sel_x < near_limit_reg) && (near_limit_reg < prev_x_reg);
    assign elapsed_eff   = restart_timer ? 16'd0 : elapsed_reg;

    always_comb begin
        bytes_seen_next = bytes_seen_reg;
        discard_next    = discard_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        angle_next      = angle_reg;
        return_next     = return_reg;
        elapsed_next    = elapsed_reg;
        store_wr        = 1'b0;
        push            = 1'b0;
        result          = '0;

        if (in_xfer) begin
            if (s_tuser == OP_TICK) begin
                if (elapsed_reg != ELAPSED_MAX) begin
                    elapsed_next = elapsed_reg + 16'd1;
                end
            end else if (discard_reg) begin
                discard_next = 1'b0;
            end else if (bytes_seen_reg < PAYLOAD_BYTES) begin
                store_wr        = 1'b1;
                bytes_seen_next = bytes_seen_reg + 3'd1;
            end else begin
                bytes_seen_next = 3'd0;
                push            = 1'b1;
                if (!frame_good) begin
                    // resync: drop the byte after a bad frame
                    discard_next         = 1'b1;
                    result.frame_ok      = 1'b0;
                    result.goal_seen     = 1'b0;
                    result.return_active = return_reg;
                    result.angle_tenths  = angle_reg;
                    result.goal_x        = prev_x_reg;
                end else begin
                    if (sel_x < near_limit_reg) begin
                        if (restart_timer) begin
                            elapsed_next = 16'd0;
                        end
                        if (elapsed_eff >= return_delay_reg) begin
                            return_next = 1'b1;
                        end
                    end
                    if (sel_x >= far_limit_reg) begin
                        return_next = 1'b0;
                    end
                    if (seen) begin
                        angle_next = {2'b00, sel_y, 2'b00} + ANGLE_OFFSET;
                    end
                    prev_x_next          = sel_x;
                    prev_y_next          = sel_y;
                    result.frame_ok      = 1'b1;
                    result.goal_seen     = seen;
                    result.return_active = return_next;
                    result.angle_tenths  = angle_next;
                    result.goal_x        = sel_x;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_seen_reg <= 3'd0;
            discard_reg    <= 1'b0;
            prev_x_reg     <= 8'd0;
            prev_y_reg     <= 8'd0;
            angle_reg      <= 12'd0;
            return_reg     <= 1'b0;
            elapsed_reg    <= 16'd0;
        end else begin
            bytes_seen_reg <= bytes_seen_next;
            discard_reg    <= discard_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            angle_reg      <= angle_next;
            return_reg     <= return_next;
            elapsed_reg    <= elapsed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_wr) begin
            frame_store[bytes_seen_reg] <= s_tdata;
        end
    end

    // ---------------- output buffer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (out_xfer) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= push;
                end
            end else if (!out_valid_reg) begin
                out_valid_reg <= push;
            end else if (push) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_xfer) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else begin
                out_data_reg <= result;
            end
        end else if (!out_valid_reg) begin
            out_data_reg <= result;
        end else if (push) begin
            skid_data_reg <= result;
        end
    end

endmodule

`default_nettype wire
